// ----- design/glu_pkg.sv -----
// ----------------------------------------------------------------------------
// GCD/LCM unit package
// Shared types for the GCD and LCM unit: the sequencer state encoding.
// ----------------------------------------------------------------------------
package glu_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD_DIV,
    ST_GCD_CHK,
    ST_LCM_DIV,
    ST_MUL,
    ST_DONE
  } state_e;

endpackage

// ----- design/gcd_lcm_unit.sv -----
// ----------------------------------------------------------------------------
// GCD/LCM unit
// Greatest common divisor by Euclidean remainder steps and least common
// multiple as (larger / gcd) * smaller, on one shared add/subtract unit.
// ----------------------------------------------------------------------------
// Usage: drive operand_a_i and operand_b_i and raise start; the beat is taken
// at a rising edge where start is high and busy is low. Only the low
// OPERAND_WIDTH operand bits are used. The result beat appears on
// gcd_value_o, lcm_value_o and zero_operand_o for exactly one cycle, marked
// by done_o; the receiver cannot stall it. busy is high from the cycle after
// acceptance through the done_o cycle, so one operation runs at a time.
// Sequence: if an operand is zero, the unit goes straight to the done_o
// cycle. Otherwise each Euclidean remainder step is a restoring division
// followed by a check state, then one more division for larger / gcd, a
// shift-add multiplication and the done_o cycle. All steps share the single
// adder of OPERAND_WIDTH + 1 bits. The next beat can be taken in the cycle
// after done_o. Reset returns the sequencer to idle; no result is lost at
// reset other than the one in flight.
// ----------------------------------------------------------------------------
module gcd_lcm_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        done_o,
  output logic [31:0] gcd_value_o,
  output logic [63:0] lcm_value_o,
  output logic        zero_operand_o
);

  localparam int W     = OPERAND_WIDTH;
  localparam int CNT_W = $clog2(W);

  glu_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     big_q, big_d;
  logic [W-1:0]     small_q, small_d;
  logic [W-1:0]     dvsr_q, dvsr_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     quo_q, quo_d;
  logic [W-1:0]     gcd_q, gcd_d;
  logic [2*W-1:0]   prod_q, prod_d;
  logic             zero_q, zero_d;

  logic [W-1:0]     op_a, op_b, op_big, op_small;
  logic [W:0]       add_x, add_y;
  logic             add_sub;
  logic [W+1:0]     add_sum;
  logic             div_ge;
  logic [2*W:0]     mul_ext;
  logic             cnt_last;

  assign op_a     = operand_a_i[W-1:0];
  assign op_b     = operand_b_i[W-1:0];
  assign op_big   = (op_a > op_b) ? op_a : op_b;
  assign op_small = (op_a > op_b) ? op_b : op_a;
  assign cnt_last = (cnt_q == CNT_W'(W - 1));

  // The shared add/subtract unit: division steps subtract, multiply steps add.
  always_comb begin
    if (state_q == glu_pkg::ST_MUL) begin
      add_x   = {1'b0, prod_q[2*W-1:W]};
      add_y   = {1'b0, small_q};
      add_sub = 1'b0;
    end else begin
      add_x   = {rem_q, quo_q[W-1]};
      add_y   = {1'b0, dvsr_q};
      add_sub = 1'b1;
    end
    add_sum = {1'b0, add_x} + {1'b0, add_y ^ {(W+1){add_sub}}} + {{(W+1){1'b0}}, add_sub};
  end

  assign div_ge  = add_sum[W+1];
  assign mul_ext = prod_q[0] ? {add_sum[W:0], prod_q[W-1:0]} : {1'b0, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glu_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    big_q   <= big_d;
    small_q <= small_d;
    dvsr_q  <= dvsr_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    gcd_q   <= gcd_d;
    prod_q  <= prod_d;
    zero_q  <= zero_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    big_d   = big_q;
    small_d = small_q;
    dvsr_d  = dvsr_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    gcd_d   = gcd_q;
    prod_d  = prod_q;
    zero_d  = zero_q;

    unique case (state_q)
      glu_pkg::ST_IDLE: begin
        if (start) begin
          big_d   = op_big;
          small_d = op_small;
          cnt_d   = '0;
          if (op_small == '0) begin
            zero_d  = 1'b1;
            gcd_d   = op_big;
            prod_d  = '0;
            state_d = glu_pkg::ST_DONE;
          end else begin
            zero_d  = 1'b0;
            dvsr_d  = op_small;
            quo_d   = op_big;
            rem_d   = '0;
            state_d = glu_pkg::ST_GCD_DIV;
          end
        end
      end
      glu_pkg::ST_GCD_DIV, glu_pkg::ST_LCM_DIV: begin
        rem_d = div_ge ? add_sum[W-1:0] : add_x[W-1:0];
        quo_d = {quo_q[W-2:0], div_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_last) begin
          cnt_d = '0;
          if (state_q == glu_pkg::ST_GCD_DIV) begin
            state_d = glu_pkg::ST_GCD_CHK;
          end else begin
            prod_d  = {{W{1'b0}}, quo_d};
            state_d = glu_pkg::ST_MUL;
          end
        end
      end
      glu_pkg::ST_GCD_CHK: begin
        rem_d = '0;
        if (rem_q == '0) begin
          gcd_d   = dvsr_q;
          quo_d   = big_q;
          state_d = glu_pkg::ST_LCM_DIV;
        end else begin
          quo_d   = dvsr_q;
          dvsr_d  = rem_q;
          state_d = glu_pkg::ST_GCD_DIV;
        end
      end
      glu_pkg::ST_MUL: begin
        prod_d = mul_ext[2*W:1];
        cnt_d  = cnt_q + 1'b1;
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = glu_pkg::ST_DONE;
        end
      end
      glu_pkg::ST_DONE: begin
        state_d = glu_pkg::ST_IDLE;
      end
      default: begin
        state_d = glu_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy           = (state_q != glu_pkg::ST_IDLE);
  assign done_o         = (state_q == glu_pkg::ST_DONE);
  assign gcd_value_o    = 32'(gcd_q);
  assign lcm_value_o    = 64'(prod_q);
  assign zero_operand_o = zero_q;

endmodule

// ----- tb/gcd_lcm_unit_tb.sv -----
// ----------------------------------------------------------------------------
// GCD/LCM unit testbench
// Drives operand pairs into the unit through its start/busy command port and
// checks every done_o beat against a software prediction of the greatest
// common divisor, the double-width least common multiple and the zero flag.
// A directed set of edge pairs is followed by random pairs of mixed size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcd_lcm_unit_tb;

  localparam int OPW = 32;
  localparam logic [31:0] OPERAND_MASK = 32'((64'd1 << OPW) - 64'd1);
  localparam int RANDOM_BEATS = 1400;
  localparam int DRAIN_CYCLES = 2000;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] gcd;
    logic [63:0] lcm;
    logic        zero;
  } gcd_lcm_t;

  class gcd_lcm_scoreboard;
    gcd_lcm_t    pending_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function gcd_lcm_t predict(logic [31:0] a_raw, logic [31:0] b_raw);
      logic [31:0] a, b, hi, lo, x, y, r;
      gcd_lcm_t res;
      a = a_raw & OPERAND_MASK;
      b = b_raw & OPERAND_MASK;
      hi = (a > b) ? a : b;
      lo = (a > b) ? b : a;
      res.zero = (a == '0) || (b == '0);
      if (res.zero) begin
        res.gcd = hi;
        res.lcm = '0;
      end else begin
        x = hi;
        y = lo;
        while (y != '0) begin
          r = x % y;
          x = y;
          y = r;
        end
        res.gcd = x;
        res.lcm = 64'(hi / x) * 64'(lo);
      end
      return res;
    endfunction

    function void note_operands(logic [31:0] a, logic [31:0] b);
      pending_q.push_back(predict(a, b));
    endfunction

    function void check_result(logic [31:0] gcd, logic [63:0] lcm, logic zero);
      gcd_lcm_t exp_res;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat gcd %h lcm %h zero %b",
                 $time, gcd, lcm, zero);
        mismatches++;
        return;
      end
      exp_res = pending_q.pop_front();
      if (gcd !== exp_res.gcd) begin
        $display("%0t: gcd_value expected %h actual %h", $time, exp_res.gcd, gcd);
        mismatches++;
      end
      if (lcm !== exp_res.lcm) begin
        $display("%0t: lcm_value expected %h actual %h", $time, exp_res.lcm, lcm);
        mismatches++;
      end
      if (zero !== exp_res.zero) begin
        $display("%0t: zero_operand expected %b actual %b", $time, exp_res.zero, zero);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] operand_a_i;
  logic [31:0] operand_b_i;
  logic        done_o;
  logic [31:0] gcd_value_o;
  logic [63:0] lcm_value_o;
  logic        zero_operand_o;

  gcd_lcm_scoreboard sb;
  int unsigned       stall_cycles;

  gcd_lcm_unit #(
    .OPERAND_WIDTH(OPW)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .done_o        (done_o),
    .gcd_value_o   (gcd_value_o),
    .lcm_value_o   (lcm_value_o),
    .zero_operand_o(zero_operand_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        sb.note_operands(operand_a_i, operand_b_i);
      end
      if (done_o) begin
        sb.check_result(gcd_value_o, lcm_value_o, zero_operand_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_bits(int unsigned nbits);
    if (nbits >= 32) begin
      return $urandom;
    end
    return $urandom & ((32'd1 << nbits) - 32'd1);
  endfunction

  task automatic send_beat(logic [31:0] a, logic [31:0] b, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    operand_a_i <= a;
    operand_b_i <= b;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_random_pair(int unsigned gap);
    int unsigned kind, wg;
    logic [31:0] a, b, g, tmp;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      a = '0;
      b = rand_bits($urandom_range(0, 32));
    end else if (kind < 13) begin
      a = rand_bits($urandom_range(1, 32));
      b = a;
    end else if (kind < 45) begin
      wg = $urandom_range(1, 16);
      g = rand_bits(wg) | 32'd1;
      a = g * rand_bits($urandom_range(1, 32 - wg));
      b = g * rand_bits($urandom_range(1, 32 - wg));
    end else if (kind < 55) begin
      a = $urandom;
      b = $urandom;
    end else begin
      a = rand_bits($urandom_range(1, 32));
      b = rand_bits($urandom_range(1, 32));
    end
    if ($urandom_range(0, 1) == 1) begin
      tmp = a;
      a = b;
      b = tmp;
    end
    send_beat(a, b, gap);
  endtask

  initial begin
    logic [31:0] dir_a[$];
    logic [31:0] dir_b[$];
    int unsigned gap;
    sb = new();
    rst_ni <= 1'b0;
    start <= 1'b0;
    operand_a_i <= '0;
    operand_b_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_a = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'd1, 32'hFFFF_FFFF, 32'd2971215073, 32'd1836311903,
              32'd4294967291, 32'd12, 32'd7, 32'h8000_0000, 32'hAAAA_AAAA,
              32'hFFFF_0000, 32'd0, 32'd65536, 32'h0000_FFFF, 32'd3};
    dir_b = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd1,
              32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd1836311903, 32'd2971215073,
              32'd4294967279, 32'd18, 32'd7, 32'h4000_0000, 32'h5555_5555,
              32'h0000_FFFF, 32'd1, 32'd65537, 32'hFFFF_0000, 32'h8000_0000};
    foreach (dir_a[i]) begin
      send_beat(dir_a[i], dir_b[i], $urandom_range(0, 10));
    end

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      gap = (((n / 50) % 4) == 3) ? 0 : $urandom_range(0, 10);
      send_random_pair(gap);
    end
    start <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
